// ===== sv/bdhr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdhr_pkg
// Types and constants shared by the button debounce / hold repeat block.
// ----------------------------------------------------------------------------
package bdhr_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned MsW   = 16;
  localparam int unsigned IdxW  = 3;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DOWN     = 3'd1,
    ST_POSTDOWN = 3'd2,
    ST_HOLD     = 3'd3,
    ST_IMPULSE  = 3'd4,
    ST_UP       = 3'd5,
    ST_POSTUP   = 3'd6
  } state_t;

  localparam logic [IdxW-1:0] REG_IDLE_LEVEL       = 3'd0;
  localparam logic [IdxW-1:0] REG_REPEAT_ENABLE    = 3'd1;
  localparam logic [IdxW-1:0] REG_DEBOUNCE_MS      = 3'd2;
  localparam logic [IdxW-1:0] REG_FIRST_REPEAT_MS  = 3'd3;
  localparam logic [IdxW-1:0] REG_REPEAT_PERIOD_MS = 3'd4;

  typedef struct packed {
    logic             idle_level;
    logic             repeat_enable;
    logic [MsW-1:0]   debounce_ms;
    logic [MsW-1:0]   first_repeat_ms;
    logic [MsW-1:0]   repeat_period_ms;
  } cfg_t;

  // one registered poll, elapsed time already worked out
  typedef struct packed {
    logic             pin;
    logic [TimeW-1:0] passed;
    logic             no_time;
  } poll_t;

  typedef struct packed {
    logic   key_down;
    logic   key_up;
    state_t state;
  } result_t;

endpackage

// ===== sv/bdhr_poll_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdhr_poll_reg
// Input register: captures a poll and the time passed since the last poll.
// ----------------------------------------------------------------------------
module bdhr_poll_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          advance,
  input  logic                          pin_level,
  input  logic [bdhr_pkg::TimeW-1:0]    now_ms,
  output logic                          valid,
  output bdhr_pkg::poll_t               poll
);

  // last_tick always ends up equal to the previous poll's timestamp
  logic [bdhr_pkg::TimeW-1:0] last_tick;
  logic [bdhr_pkg::TimeW-1:0] passed_next;

  assign passed_next = now_ms - last_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      last_tick <= '0;
    end else begin
      if (accept) begin
        valid     <= 1'b1;
        last_tick <= now_ms;
      end else if (advance) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      poll.pin     <= pin_level;
      poll.passed  <= passed_next;
      poll.no_time <= (passed_next == '0);
    end
  end

endmodule

// ===== sv/bdhr_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdhr_fsm
// Button state machine with the elapsed-time counter; one poll per cycle while fire is high.
// ----------------------------------------------------------------------------
module bdhr_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  bdhr_pkg::poll_t   poll,
  input  bdhr_pkg::cfg_t    cfg,
  output bdhr_pkg::result_t result
);

  bdhr_pkg::state_t                 mode, mode_next, mode_ft;
  logic [bdhr_pkg::TimeW-1:0]       elapsed_count, elapsed_next, cnt_ft;
  logic                             repeat_started, repeat_next, rs_ft;
  logic                             released;
  logic [bdhr_pkg::MsW-1:0]         limit;
  logic [bdhr_pkg::TimeW:0]         sum_raw;
  logic [bdhr_pkg::TimeW-1:0]       sum;
  logic                             over;

  assign released = (poll.pin == cfg.idle_level);

  // one-shot states fall through first
  always_comb begin
    mode_ft = mode;
    cnt_ft  = elapsed_count;
    rs_ft   = repeat_started;
    unique case (mode)
      bdhr_pkg::ST_DOWN: begin
        mode_ft = bdhr_pkg::ST_POSTDOWN;
        cnt_ft  = '0;
      end
      bdhr_pkg::ST_UP: begin
        mode_ft = bdhr_pkg::ST_POSTUP;
        cnt_ft  = '0;
      end
      bdhr_pkg::ST_IMPULSE: begin
        mode_ft = bdhr_pkg::ST_HOLD;
        rs_ft   = 1'b1;
        cnt_ft  = '0;
      end
      default: ;
    endcase
  end

  // shared saturating add and compare
  always_comb begin
    if (mode_ft == bdhr_pkg::ST_HOLD) begin
      limit = rs_ft ? cfg.repeat_period_ms : cfg.first_repeat_ms;
    end else begin
      limit = cfg.debounce_ms;
    end
    sum_raw = {1'b0, cnt_ft} + {1'b0, poll.passed};
    sum     = sum_raw[bdhr_pkg::TimeW] ? '1 : sum_raw[bdhr_pkg::TimeW-1:0];
    over    = (sum > {{(bdhr_pkg::TimeW-bdhr_pkg::MsW){1'b0}}, limit});
  end

  // next state
  always_comb begin
    mode_next    = mode_ft;
    elapsed_next = cnt_ft;
    repeat_next  = rs_ft;
    if (!poll.no_time) begin
      unique case (mode_ft)
        bdhr_pkg::ST_IDLE: begin
          if (!released) mode_next = bdhr_pkg::ST_DOWN;
        end
        bdhr_pkg::ST_POSTDOWN: begin
          if (over) begin
            mode_next    = bdhr_pkg::ST_HOLD;
            repeat_next  = 1'b0;
            elapsed_next = '0;
          end else begin
            elapsed_next = sum;
          end
        end
        bdhr_pkg::ST_HOLD: begin
          if (cfg.repeat_enable) elapsed_next = sum;
          if (cfg.repeat_enable && over) begin
            mode_next = bdhr_pkg::ST_IMPULSE;
          end else if (released) begin
            mode_next = bdhr_pkg::ST_UP;
          end
        end
        bdhr_pkg::ST_POSTUP: begin
          elapsed_next = sum;
          if (over) mode_next = bdhr_pkg::ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  // event flags
  always_comb begin
    result.key_down = 1'b0;
    result.key_up   = 1'b0;
    result.state    = mode_next;
    if (!poll.no_time) begin
      unique case (mode_ft)
        bdhr_pkg::ST_IDLE: result.key_down = !released;
        bdhr_pkg::ST_HOLD: begin
          if (cfg.repeat_enable && over) begin
            result.key_down = 1'b1;
          end else begin
            result.key_up = released;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= bdhr_pkg::ST_IDLE;
      elapsed_count  <= '0;
      repeat_started <= 1'b0;
    end else if (fire) begin
      mode           <= mode_next;
      elapsed_count  <= elapsed_next;
      repeat_started <= repeat_next;
    end
  end

endmodule

// ===== sv/button_debounce_hold_repeat_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_hold_repeat_core
// Push-button debouncer with key-down / key-up events and hold auto-repeat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat is one poll carrying the
//   raw pin level and a free-running millisecond timestamp.
//   Output channel (out_valid / out_stall): exactly one beat per poll with
//   the key-down and key-up flags and the state code after the poll.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while no poll is in flight. Unknown indexes are dropped.
// Timing:
//   A poll lands in the input register, then the state machine updates and
//   the result register loads once the output side advances. One poll per
//   cycle sustained while the output is not stalled; the state update
//   (one saturating 32-bit add and compare) is combinational.
// Reset (rst, synchronous): state idle, counter and last timestamp zero,
//   registers back to idle level 1, repeat off, 20 / 500 / 100 ms.
// Backpressure: when out_stall holds a result, the input register keeps its
//   poll and in_stall rises once it is full; nothing is dropped.
// ----------------------------------------------------------------------------
module button_debounce_hold_repeat_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         pin_level,
  input  logic [bdhr_pkg::TimeW-1:0]   now_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         key_down_event,
  output logic                         key_up_event,
  output logic [2:0]                   button_state,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bdhr_pkg::IdxW-1:0]    cfg_index,
  input  logic [bdhr_pkg::MsW-1:0]     cfg_data
);

  bdhr_pkg::cfg_t    cfg;
  bdhr_pkg::poll_t   poll;
  bdhr_pkg::result_t result;
  logic              poll_valid;
  logic              advance;
  logic              accept;
  logic              fire;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = poll_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign fire      = poll_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_level       <= 1'b1;
      cfg.repeat_enable    <= 1'b0;
      cfg.debounce_ms      <= 16'd20;
      cfg.first_repeat_ms  <= 16'd500;
      cfg.repeat_period_ms <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bdhr_pkg::REG_IDLE_LEVEL:       cfg.idle_level       <= cfg_data[0];
        bdhr_pkg::REG_REPEAT_ENABLE:    cfg.repeat_enable    <= cfg_data[0];
        bdhr_pkg::REG_DEBOUNCE_MS:      cfg.debounce_ms      <= cfg_data;
        bdhr_pkg::REG_FIRST_REPEAT_MS:  cfg.first_repeat_ms  <= cfg_data;
        bdhr_pkg::REG_REPEAT_PERIOD_MS: cfg.repeat_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  bdhr_poll_reg u_poll_reg (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .advance   (advance),
    .pin_level (pin_level),
    .now_ms    (now_ms),
    .valid     (poll_valid),
    .poll      (poll)
  );

  bdhr_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .poll   (poll),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      key_down_event <= result.key_down;
      key_up_event   <= result.key_up;
      button_state   <= result.state;
    end
  end

  // a poll never reports both edges
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(key_down_event && key_up_event))
    else $error("key-down and key-up on the same beat");

  // release always lands in the up state
  a_up_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_up_event) |-> (button_state == bdhr_pkg::ST_UP))
    else $error("key-up without up state");

  // press or repeat always lands in a one-shot down state
  a_down_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_down_event) |->
      (button_state == bdhr_pkg::ST_DOWN || button_state == bdhr_pkg::ST_IMPULSE))
    else $error("key-down without down or impulse state");

  // input register cannot be stalled while the output side is free
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid) |-> !in_stall)
    else $error("input stalled with empty output register");

endmodule
